/* hdl/bal_pkg.sv */
// Shared types and constants for the bounded array list block.
// Used by every module under hdl but bal_ram; depends on nothing.
package bal_pkg;

    localparam int FUNC_W      = 3;
    localparam int POS_W       = 5;
    localparam int VAL_W       = 32;
    localparam int CNT_OUT_W   = 5;
    localparam int CAP_W       = 5;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int DEPTH_DEF   = 16;
    localparam int WORD_W_DEF  = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;
    localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'd0;

    typedef enum logic [FUNC_W-1:0] {
        F_INSERT   = 3'd0,
        F_APPEND   = 3'd1,
        F_DELETE   = 3'd2,
        F_DEL_LAST = 3'd3,
        F_READ     = 3'd4
    } t_bal_func;

    typedef enum logic [1:0] {
        RD_POS,
        RD_IDX_M1,
        RD_IDX_P1
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_AT_CNT_WORD,
        WR_AT_POS_WORD,
        WR_AT_IDX_RDATA
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_CNT,
        IDX_LOAD_POS,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_bal_in;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] read_data;
        logic [CNT_OUT_W-1:0]    entry_count;
    } t_bal_out;

    typedef struct packed {
        logic    load;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_idx_op idx_op;
        logic    done;
        logic    ok;
        t_cnt_op cnt_op;
        logic    take_rdata;
    } t_bal_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ins_ok;
        logic              app_ok;
        logic              pos_ok;
        logic              nonempty;
        logic              at_pos;
        logic              del_end;
    } t_bal_sts;

endpackage

/* hdl/bounded_array_list_core.sv */
// Top level of the bounded array list: APB capacity register, sequencer and
// datapath. Depends on bal_pkg, bal_ctrl, bal_dp (and bal_ram through bal_dp).
//
//  channel   handshake                         payload
//  command   start, busy (accept: start & !busy) i_cmd    (t_bal_in)
//  result    o_result_valid, one-cycle strobe   o_result (t_bal_out)
//  config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// Append, delete last and failed operations finish in the evaluate state; read
// waits on the registered read data; insert at p moves the words from p to the
// end up by one, last first, and delete at p moves those above p down by one.
// Each shifted word costs a read and a write of the entry memory. A new command
// is taken in the strobe cycle. Reset is synchronous; count clears, capacity
// returns to 16, entries hold no defined value. Results cannot be stalled.
module bounded_array_list_core
    import bal_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_bal_in           i_cmd,
    output logic              o_result_valid,
    output t_bal_out          o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CAP_W-1:0] r_capacity;
    logic             cap_sel;
    t_bal_cmd         cmd;
    t_bal_sts         sts;

    assign cap_sel = (paddr[APB_AW-1:2] == ADDR_CAPACITY[APB_AW-1:2]);
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? APB_DW'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && cap_sel) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    bal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bal_dp #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_in       (i_cmd),
        .i_capacity     (r_capacity),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

/* hdl/bal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/bal_ctrl.sv */
// Sequencer for the list operations: decodes the operation, steps the
// entry shifts one word at a time. Depends on bal_pkg.
module bal_ctrl
    import bal_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_bal_sts i_sts,
    output t_bal_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SH_TEST,
        S_SH_MOVE,
        S_DL_TEST,
        S_DL_MOVE,
        S_RD_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.rd_sel     = RD_POS;
        o_cmd.wr_sel     = WR_AT_CNT_WORD;
        o_cmd.idx_op     = IDX_HOLD;
        o_cmd.cnt_op     = CNT_HOLD;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                case (i_sts.func)
                    F_INSERT: begin
                        if (i_sts.ins_ok) begin
                            o_cmd.idx_op = IDX_LOAD_CNT;
                            n_state      = S_SH_TEST;
                        end else begin
                            o_cmd.done = 1'b1;
                        end
                    end
                    F_APPEND: begin
                        o_cmd.done = 1'b1;
                        if (i_sts.app_ok) begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_AT_CNT_WORD;
                            o_cmd.ok     = 1'b1;
                            o_cmd.cnt_op = CNT_INC;
                        end
                    end
                    F_DELETE: begin
                        if (i_sts.pos_ok) begin
                            o_cmd.idx_op = IDX_LOAD_POS;
                            n_state      = S_DL_TEST;
                        end else begin
                            o_cmd.done = 1'b1;
                        end
                    end
                    F_DEL_LAST: begin
                        o_cmd.done = 1'b1;
                        if (i_sts.nonempty) begin
                            o_cmd.ok     = 1'b1;
                            o_cmd.cnt_op = CNT_DEC;
                        end
                    end
                    F_READ: begin
                        if (i_sts.pos_ok) begin
                            o_cmd.rd_sel = RD_POS;
                            n_state      = S_RD_WAIT;
                        end else begin
                            o_cmd.done = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.done = 1'b1;
                    end
                endcase
            end
            S_SH_TEST: begin
                if (i_sts.at_pos) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_AT_POS_WORD;
                    o_cmd.done   = 1'b1;
                    o_cmd.ok     = 1'b1;
                    o_cmd.cnt_op = CNT_INC;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_IDX_M1;
                    n_state      = S_SH_MOVE;
                end
            end
            S_SH_MOVE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_AT_IDX_RDATA;
                o_cmd.idx_op = IDX_DEC;
                n_state      = S_SH_TEST;
            end
            S_DL_TEST: begin
                if (i_sts.del_end) begin
                    o_cmd.done   = 1'b1;
                    o_cmd.ok     = 1'b1;
                    o_cmd.cnt_op = CNT_DEC;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_sel = RD_IDX_P1;
                    n_state      = S_DL_MOVE;
                end
            end
            S_DL_MOVE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_AT_IDX_RDATA;
                o_cmd.idx_op = IDX_INC;
                n_state      = S_DL_TEST;
            end
            S_RD_WAIT: begin
                o_cmd.done       = 1'b1;
                o_cmd.ok         = 1'b1;
                o_cmd.take_rdata = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> r_state == S_IDLE)
        else $error("operation finished but sequencer did not return to idle");

    a_load_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_EVAL)
        else $error("transaction accepted but not evaluated next cycle");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_cmd.wr_en && !o_cmd.done))
        else $error("memory write or completion while idle");

endmodule

/* hdl/bal_dp.sv */
// Datapath: operand registers, entry count, shift index, entry memory and
// result register. Depends on bal_pkg and bal_ram.
module bal_dp
    import bal_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_bal_in          i_cmd_in,
    input  logic [CAP_W-1:0] i_capacity,
    input  t_bal_cmd         i_cmd,
    output t_bal_sts         o_sts,
    output logic             o_result_valid,
    output t_bal_out         o_result
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LW    = (CNT_W > POS_W) ? ((CNT_W > CAP_W) ? CNT_W : CAP_W)
                                           : ((POS_W > CAP_W) ? POS_W : CAP_W);

    logic [FUNC_W-1:0]     r_func;
    logic [LW-1:0]         r_pos;
    logic [WORD_WIDTH-1:0] r_word;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_idx;
    logic                  r_out_valid;
    t_bal_out              r_result;

    logic [LW-1:0]         cnt_l;
    logic [LW-1:0]         cap_l;
    logic [LW-1:0]         lim_l;
    logic [LW:0]           idx_p1;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic [WORD_WIDTH-1:0] wdata;
    logic [WORD_WIDTH-1:0] rdata;

    assign cnt_l  = LW'(r_count);
    assign cap_l  = LW'(i_capacity);
    assign lim_l  = (cap_l > LW'(DEPTH)) ? LW'(DEPTH) : cap_l;
    assign idx_p1 = (LW + 1)'(r_idx) + (LW + 1)'(1);

    assign o_sts.func     = r_func;
    assign o_sts.app_ok   = (cnt_l < lim_l);
    assign o_sts.ins_ok   = (cnt_l < lim_l) && (r_pos <= cnt_l);
    assign o_sts.pos_ok   = (r_pos < cnt_l);
    assign o_sts.nonempty = (r_count != '0);
    assign o_sts.at_pos   = (LW'(r_idx) == r_pos);
    assign o_sts.del_end  = (idx_p1 >= (LW + 1)'(r_count));

    always_comb begin
        case (i_cmd.rd_sel)
            RD_IDX_M1: raddr = AW'(r_idx - CNT_W'(1));
            RD_IDX_P1: raddr = AW'(idx_p1);
            default:   raddr = AW'(r_pos);
        endcase
        case (i_cmd.wr_sel)
            WR_AT_POS_WORD: begin
                waddr = AW'(r_pos);
                wdata = r_word;
            end
            WR_AT_IDX_RDATA: begin
                waddr = AW'(r_idx);
                wdata = rdata;
            end
            default: begin
                waddr = AW'(r_count);
                wdata = r_word;
            end
        endcase
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CNT_W'(1);
            CNT_DEC: n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    bal_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_cmd_in.func;
            r_pos  <= LW'(i_cmd_in.position);
            r_word <= WORD_WIDTH'($unsigned(i_cmd_in.value));
        end
        case (i_cmd.idx_op)
            IDX_LOAD_CNT: r_idx <= r_count;
            IDX_LOAD_POS: r_idx <= CNT_W'(r_pos);
            IDX_DEC:      r_idx <= r_idx - CNT_W'(1);
            IDX_INC:      r_idx <= r_idx + CNT_W'(1);
            default:      r_idx <= r_idx;
        endcase
        if (i_cmd.done) begin
            r_result.ok          <= i_cmd.ok;
            r_result.read_data   <= i_cmd.take_rdata ? VAL_W'(rdata) : '0;
            r_result.entry_count <= CNT_OUT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.done;
            if (i_cmd.done) begin
                r_count <= n_count;
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_count) <= LW'(DEPTH))
        else $error("entry count above memory depth");

    a_count_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.done |=> $stable(r_count))
        else $error("entry count changed outside completion");

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !i_cmd.done)
        else $error("back-to-back result strobes");

endmodule
